/* sv/sxl_pkg.sv */
// Shared types, character codes and helper functions for the s-expression lexer.
// Used by sexpr_token_lexer and its port checker; no dependencies.
`default_nettype none

package sxl_pkg;

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_WORD,
        MODE_STR,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT
    } mode_t;

    typedef enum logic [3:0] {
        SH_START,
        SH_SIGN,
        SH_INT,
        SH_DOT,
        SH_FRAC,
        SH_EXP,
        SH_EXPSIGN,
        SH_EXPDIG,
        SH_BAD
    } shape_t;

    typedef enum logic [2:0] {
        KIND_LEFT,
        KIND_RIGHT,
        KIND_BAR,
        KIND_STRING,
        KIND_NUMBER,
        KIND_SYMBOL,
        KIND_EOI,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        logic       last;
        kind_t      kind;
        logic       token_end;
        logic       has_text;
        logic [7:0] text;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
        mode_t   mode;
        logic    line_reset;
    } str_res_t;

    localparam int unsigned REG_BAR_IS_TOKEN = 0;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    function automatic result_t make_res(input logic [7:0] text, input logic has_text,
                                         input logic token_end, input kind_t kind);
        result_t r;
        r.last      = 1'b0;
        r.kind      = kind;
        r.token_end = token_end;
        r.has_text  = has_text;
        r.text      = text;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF)
            || (c == CH_NUL);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    function automatic logic is_sep(input logic [7:0] c, input logic bar);
        return is_space(c) || (c == CH_LPAREN) || (c == CH_RPAREN)
            || (bar && (c == CH_BAR));
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_digit(c)) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        if ((c >= "a") && (c <= "f")) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if ((c >= "A") && (c <= "F")) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

    // Bit 8 flags a single-letter escape, bits 7:0 carry the decoded byte.
    function automatic logic [8:0] esc_letter(input logic [7:0] c);
        logic [8:0] r;
        r = 9'b0;
        if (c == CH_QUOTE)  r = {1'b1, CH_QUOTE};
        if (c == CH_BSLASH) r = {1'b1, CH_BSLASH};
        if (c == "a")       r = {1'b1, CH_BEL};
        if (c == "b")       r = {1'b1, CH_BS};
        if (c == "f")       r = {1'b1, CH_FF};
        if (c == "n")       r = {1'b1, CH_LF};
        if (c == "r")       r = {1'b1, CH_CR};
        if (c == "t")       r = {1'b1, CH_TAB};
        if (c == "v")       r = {1'b1, CH_VT};
        return r;
    endfunction

    function automatic shape_t shape_step(input shape_t s, input logic [7:0] c);
        logic d;
        logic sg;
        logic e;
        shape_t n;
        d  = is_digit(c);
        sg = (c == CH_PLUS) || (c == CH_MINUS);
        e  = (c == "e") || (c == "E");
        n  = SH_BAD;
        unique case (s)
            SH_START:   n = sg ? SH_SIGN : d ? SH_INT : (c == CH_DOT) ? SH_DOT : SH_BAD;
            SH_SIGN:    n = d ? SH_INT : (c == CH_DOT) ? SH_DOT : SH_BAD;
            SH_INT:     n = d ? SH_INT : (c == CH_DOT) ? SH_FRAC : e ? SH_EXP : SH_BAD;
            SH_DOT:     n = d ? SH_FRAC : SH_BAD;
            SH_FRAC:    n = d ? SH_FRAC : e ? SH_EXP : SH_BAD;
            SH_EXP:     n = sg ? SH_EXPSIGN : d ? SH_EXPDIG : SH_BAD;
            SH_EXPSIGN: n = d ? SH_EXPDIG : SH_BAD;
            SH_EXPDIG:  n = d ? SH_EXPDIG : SH_BAD;
            default:    n = SH_BAD;
        endcase
        return n;
    endfunction

    function automatic kind_t word_kind(input shape_t s);
        return ((s == SH_INT) || (s == SH_FRAC) || (s == SH_EXPDIG)) ? KIND_NUMBER
                                                                     : KIND_SYMBOL;
    endfunction

    // Ordinary byte inside a string: close, start an escape, error on newline, or text.
    function automatic str_res_t str_byte(input logic [7:0] c);
        str_res_t r;
        r.emit       = 1'b1;
        r.res        = make_res(c, 1'b1, 1'b0, KIND_STRING);
        r.mode       = MODE_STR;
        r.line_reset = 1'b0;
        if (c == CH_QUOTE) begin
            r.res  = make_res(CH_NUL, 1'b0, 1'b1, KIND_STRING);
            r.mode = MODE_BETWEEN;
        end else if (c == CH_BSLASH) begin
            r.emit = 1'b0;
            r.mode = MODE_ESC;
        end else if (c == CH_LF) begin
            r.res        = make_res(CH_NUL, 1'b0, 1'b1, KIND_ERROR);
            r.mode       = MODE_BETWEEN;
            r.line_reset = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/sexpr_token_lexer.sv */
// sexpr_token_lexer: one text byte per item in, token results out.
// Latency: results of an item enter the output queue at the accepting edge and
// are shown from the next cycle on. Throughput: one item per cycle while items
// give at most one result; an item with two results is read out one at a time,
// and s_tready drops while the 4-entry result queue holds more than two.
// Reset (rst_n low, asynchronous): line start, queue empty, bar_is_token = 1.
`default_nettype none

module sexpr_token_lexer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte
    input  wire         s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // text_byte
    output logic        m_tlast,   // token_end
    output logic [4:0]  m_tuser,   // has_text [0], token_kind [3:1], last_of_item [4]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sxl_pkg::*;

    logic          bar_reg;
    mode_t         mode_reg, mode_next;
    logic          line_start_reg, line_start_next;
    logic          skip_reg, skip_next;
    shape_t        shape_reg, shape_next;
    logic [1:0]    esc_cnt_reg, esc_cnt_next;
    logic [8:0]    esc_val_reg, esc_val_next;

    result_t       queue_reg [4];
    logic [1:0]    wr_ptr_reg;
    logic [1:0]    rd_ptr_reg;
    logic [2:0]    count_reg;

    result_t       res_a [2];
    logic [1:0]    res_n;
    str_res_t      sb;
    logic [4:0]    hx;
    logic [8:0]    el;
    logic [8:0]    oct_val;
    logic [1:0]    oct_cnt;
    logic [7:0]    c;
    logic          accept;
    logic          pop;
    logic          cfg_wr;

    assign c      = s_tdata;
    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == 1'(REG_BAR_IS_TOKEN));

    always_comb
    begin
        prdata = 32'b0;
        if (paddr[2] == 1'(REG_BAR_IS_TOKEN))
            prdata = {31'b0, bar_reg};
    end

    // Next state and up to two results for the item on the input.
    always_comb
    begin
        mode_next       = mode_reg;
        line_start_next = line_start_reg;
        skip_next       = skip_reg;
        shape_next      = shape_reg;
        esc_cnt_next    = esc_cnt_reg;
        esc_val_next    = esc_val_reg;
        res_n           = 2'd0;
        res_a[0]        = '0;
        res_a[1]        = '0;
        sb              = str_byte(c);
        hx              = hex_digit(c);
        el              = esc_letter(c);
        oct_val         = {esc_val_reg[5:0], c[2:0]};
        oct_cnt         = esc_cnt_reg + 2'd1;

        if (s_tlast) begin
            if (mode_reg == MODE_WORD) begin
                res_a[res_n[0]] = make_res(CH_NUL, 1'b0, 1'b1, word_kind(shape_reg));
                res_n = res_n + 2'd1;
            end else if (mode_reg != MODE_BETWEEN) begin
                res_a[res_n[0]] = make_res(CH_NUL, 1'b0, 1'b1, KIND_ERROR);
                res_n = res_n + 2'd1;
            end
            res_a[res_n[0]] = make_res(CH_NUL, 1'b0, 1'b1, KIND_EOI);
            res_n = res_n + 2'd1;
            mode_next       = MODE_BETWEEN;
            line_start_next = 1'b1;
            skip_next       = 1'b0;
            shape_next      = SH_START;
            esc_cnt_next    = 2'd0;
            esc_val_next    = 9'd0;
        end else begin
            unique case (mode_reg)
                MODE_WORD:
                begin
                    if (is_sep(c, bar_reg)) begin
                        res_a[res_n[0]] = make_res(CH_NUL, 1'b0, 1'b1, word_kind(shape_reg));
                        res_n = res_n + 2'd1;
                        mode_next  = MODE_BETWEEN;
                        shape_next = SH_START;
                        // separator handled as between tokens, mid-line
                        if (c == CH_LF) begin
                            line_start_next = 1'b1;
                        end else if (c == CH_LPAREN) begin
                            res_a[res_n[0]] = make_res(c, 1'b1, 1'b1, KIND_LEFT);
                            res_n = res_n + 2'd1;
                        end else if (c == CH_RPAREN) begin
                            res_a[res_n[0]] = make_res(c, 1'b1, 1'b1, KIND_RIGHT);
                            res_n = res_n + 2'd1;
                        end else if (c == CH_BAR) begin
                            res_a[res_n[0]] = make_res(c, 1'b1, 1'b1, KIND_BAR);
                            res_n = res_n + 2'd1;
                        end
                    end else begin
                        shape_next = shape_step(shape_reg, c);
                        res_a[res_n[0]] = make_res(c, 1'b1, 1'b0, KIND_SYMBOL);
                        res_n = res_n + 2'd1;
                    end
                end
                MODE_STR:
                begin
                    mode_next    = sb.mode;
                    esc_cnt_next = 2'd0;
                    esc_val_next = 9'd0;
                    if (sb.emit) begin
                        res_a[res_n[0]] = sb.res;
                        res_n = res_n + 2'd1;
                    end
                    if (sb.line_reset) begin
                        line_start_next = 1'b1;
                        skip_next       = 1'b0;
                        shape_next      = SH_START;
                    end
                end
                MODE_ESC:
                begin
                    if (el[8]) begin
                        res_a[res_n[0]] = make_res(el[7:0], 1'b1, 1'b0, KIND_STRING);
                        res_n = res_n + 2'd1;
                        mode_next = MODE_STR;
                    end else if (c == CH_LOW_X) begin
                        mode_next    = MODE_HEX;
                        esc_cnt_next = 2'd0;
                        esc_val_next = 9'd0;
                    end else if (is_octal(c)) begin
                        mode_next    = MODE_OCT;
                        esc_cnt_next = 2'd1;
                        esc_val_next = {6'b0, c[2:0]};
                    end else begin
                        // unknown escape: keep the backslash, then treat the byte as text
                        res_a[res_n[0]] = make_res(CH_BSLASH, 1'b1, 1'b0, KIND_STRING);
                        res_n = res_n + 2'd1;
                        mode_next    = sb.mode;
                        esc_cnt_next = 2'd0;
                        esc_val_next = 9'd0;
                        if (sb.emit) begin
                            res_a[res_n[0]] = sb.res;
                            res_n = res_n + 2'd1;
                        end
                        if (sb.line_reset) begin
                            line_start_next = 1'b1;
                            skip_next       = 1'b0;
                            shape_next      = SH_START;
                        end
                    end
                end
                MODE_HEX:
                begin
                    if (hx[4]) begin
                        if (esc_cnt_reg == 2'd0) begin
                            esc_cnt_next = 2'd1;
                            esc_val_next = {5'b0, hx[3:0]};
                        end else begin
                            res_a[res_n[0]] = make_res({esc_val_reg[3:0], hx[3:0]}, 1'b1,
                                                       1'b0, KIND_STRING);
                            res_n = res_n + 2'd1;
                            mode_next    = MODE_STR;
                            esc_cnt_next = 2'd0;
                            esc_val_next = 9'd0;
                        end
                    end else begin
                        // empty hex escape yields the letter itself
                        res_a[res_n[0]] = make_res((esc_cnt_reg != 2'd0) ? esc_val_reg[7:0]
                                                                         : CH_LOW_X,
                                                   1'b1, 1'b0, KIND_STRING);
                        res_n = res_n + 2'd1;
                        mode_next    = sb.mode;
                        esc_cnt_next = 2'd0;
                        esc_val_next = 9'd0;
                        if (sb.emit) begin
                            res_a[res_n[0]] = sb.res;
                            res_n = res_n + 2'd1;
                        end
                        if (sb.line_reset) begin
                            line_start_next = 1'b1;
                            skip_next       = 1'b0;
                            shape_next      = SH_START;
                        end
                    end
                end
                MODE_OCT:
                begin
                    if (is_octal(c)) begin
                        if (oct_cnt == 2'd3) begin
                            res_a[res_n[0]] = make_res(oct_val[7:0], 1'b1, 1'b0, KIND_STRING);
                            res_n = res_n + 2'd1;
                            mode_next    = MODE_STR;
                            esc_cnt_next = 2'd0;
                            esc_val_next = 9'd0;
                        end else begin
                            esc_cnt_next = oct_cnt;
                            esc_val_next = oct_val;
                        end
                    end else begin
                        res_a[res_n[0]] = make_res(esc_val_reg[7:0], 1'b1, 1'b0, KIND_STRING);
                        res_n = res_n + 2'd1;
                        mode_next    = sb.mode;
                        esc_cnt_next = 2'd0;
                        esc_val_next = 9'd0;
                        if (sb.emit) begin
                            res_a[res_n[0]] = sb.res;
                            res_n = res_n + 2'd1;
                        end
                        if (sb.line_reset) begin
                            line_start_next = 1'b1;
                            skip_next       = 1'b0;
                            shape_next      = SH_START;
                        end
                    end
                end
                MODE_BETWEEN:
                begin
                    if (skip_reg) begin
                        // drop the rest of a comment line
                        if (c == CH_LF) begin
                            skip_next       = 1'b0;
                            line_start_next = 1'b1;
                        end
                    end else if (is_space(c)) begin
                        if (c == CH_LF)
                            line_start_next = 1'b1;
                    end else if (line_start_reg && (c == CH_HASH)) begin
                        skip_next = 1'b1;
                    end else begin
                        line_start_next = 1'b0;
                        if (c == CH_LPAREN) begin
                            res_a[res_n[0]] = make_res(c, 1'b1, 1'b1, KIND_LEFT);
                            res_n = res_n + 2'd1;
                        end else if (c == CH_RPAREN) begin
                            res_a[res_n[0]] = make_res(c, 1'b1, 1'b1, KIND_RIGHT);
                            res_n = res_n + 2'd1;
                        end else if (bar_reg && (c == CH_BAR)) begin
                            res_a[res_n[0]] = make_res(c, 1'b1, 1'b1, KIND_BAR);
                            res_n = res_n + 2'd1;
                        end else if (c == CH_QUOTE) begin
                            mode_next    = MODE_STR;
                            esc_cnt_next = 2'd0;
                            esc_val_next = 9'd0;
                        end else begin
                            mode_next  = MODE_WORD;
                            shape_next = shape_step(SH_START, c);
                            res_a[res_n[0]] = make_res(c, 1'b1, 1'b0, KIND_SYMBOL);
                            res_n = res_n + 2'd1;
                        end
                    end
                end
                default:
                begin
                    mode_next       = MODE_BETWEEN;
                    line_start_next = 1'b1;
                    skip_next       = 1'b0;
                    shape_next      = SH_START;
                    esc_cnt_next    = 2'd0;
                    esc_val_next    = 9'd0;
                end
            endcase
        end

        if (res_n == 2'd2)
            res_a[1].last = 1'b1;
        else if (res_n == 2'd1)
            res_a[0].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bar_reg        <= 1'b1;
            mode_reg       <= MODE_BETWEEN;
            line_start_reg <= 1'b1;
            skip_reg       <= 1'b0;
            shape_reg      <= SH_START;
            esc_cnt_reg    <= 2'd0;
            esc_val_reg    <= 9'd0;
        end else begin
            if (cfg_wr)
                bar_reg <= pwdata[0];
            if (accept) begin
                mode_reg       <= mode_next;
                line_start_reg <= line_start_next;
                skip_reg       <= skip_next;
                shape_reg      <= shape_next;
                esc_cnt_reg    <= esc_cnt_next;
                esc_val_reg    <= esc_val_next;
            end
        end
    end

    // Result queue: up to two writes per accepted item, one read per cycle while m_tready is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + res_n;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (accept ? {1'b0, res_n} : 3'd0) - {2'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (res_n != 2'd0))
            queue_reg[wr_ptr_reg] <= res_a[0];
        if (accept && (res_n == 2'd2))
            queue_reg[wr_ptr_reg + 2'd1] <= res_a[1];
    end

    assign s_tready = (count_reg <= 3'd2);
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = queue_reg[rd_ptr_reg].text;
    assign m_tlast  = queue_reg[rd_ptr_reg].token_end;
    assign m_tuser  = {queue_reg[rd_ptr_reg].last, queue_reg[rd_ptr_reg].kind,
                       queue_reg[rd_ptr_reg].has_text};

endmodule

`default_nettype wire

/* sv/sxl_check.sv */
// Port-level checks for sexpr_token_lexer, attached by the bind at the end.
// Depends on sxl_pkg for the token kind codes.
`default_nettype none

module sxl_check (
    input wire       clk,
    input wire       rst_n,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast,
    input wire [4:0] m_tuser
);
    import sxl_pkg::*;

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_no_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("text byte not zero on a result without text");

    a_single_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[3:1] == KIND_LEFT || m_tuser[3:1] == KIND_RIGHT
                     || m_tuser[3:1] == KIND_BAR || m_tuser[3:1] == KIND_ERROR)
        |-> m_tlast)
        else $error("one-shot token kind without token end");

    a_eoi_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3:1] == KIND_EOI |-> m_tlast && m_tuser[4] && !m_tuser[0])
        else $error("end-of-input result malformed");

    a_number_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3:1] == KIND_NUMBER |-> m_tlast && !m_tuser[0])
        else $error("number kind on a text-carrying result");

endmodule

bind sexpr_token_lexer sxl_check u_sxl_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/sv/sexpr_token_lexer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sexpr_token_lexer: text bytes in, token items out.
// Predicts every token item from its own lexer model and checks field by field.
// Depends on sxl_pkg and the sexpr_token_lexer RTL.

module sexpr_token_lexer_test;

    import sxl_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam logic [2:0]  BAR_ADDR    = 3'(4 * REG_BAR_IS_TOKEN);

    // Predicts token items byte by byte and holds those not yet seen on the output.
    class token_scoreboard;
        result_t  pending_tokens[$];
        result_t  step_out[$];
        int       errors;
        logic     bar_tok;
        mode_t    mode;
        logic     line_start;
        logic     in_comment;
        shape_t   shape;
        logic [1:0] esc_cnt;
        logic [8:0] esc_val;

        function new();
            errors  = 0;
            bar_tok = 1'b1;
            restart_line();
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        function void note_failure(string what);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void restart_line();
            mode       = MODE_BETWEEN;
            line_start = 1'b1;
            in_comment = 1'b0;
            shape      = SH_START;
            esc_cnt    = 2'd0;
            esc_val    = 9'd0;
        endfunction

        function void push(logic [7:0] text, logic has, logic fin, kind_t kind);
            result_t r;
            r.last      = 1'b0;
            r.kind      = kind;
            r.token_end = fin;
            r.has_text  = has;
            r.text      = text;
            step_out.insert(step_out.size(), r);
        endfunction

        function logic is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_NUL;
        endfunction

        function logic is_delim(logic [7:0] c);
            return is_blank(c) || c == CH_LPAREN || c == CH_RPAREN
                || (bar_tok && c == CH_BAR);
        endfunction

        // {valid, value}
        function logic [4:0] hex_of(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return {1'b1, c[3:0]};
            if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                return {1'b1, 4'(c[3:0] + 4'd9)};
            return 5'd0;
        endfunction

        function shape_t next_shape(shape_t s, logic [7:0] c);
            logic dig;
            logic sgn;
            logic ex;
            logic dot;
            dig = c >= CH_ZERO && c <= CH_NINE;
            sgn = c == CH_PLUS || c == CH_MINUS;
            ex  = c == "e" || c == "E";
            dot = c == CH_DOT;
            case (s)
                SH_START:
                    if (sgn) return SH_SIGN;
                    else if (dig) return SH_INT;
                    else if (dot) return SH_DOT;
                SH_SIGN:
                    if (dig) return SH_INT;
                    else if (dot) return SH_DOT;
                SH_INT:
                    if (dig) return SH_INT;
                    else if (dot) return SH_FRAC;
                    else if (ex) return SH_EXP;
                SH_DOT:
                    if (dig) return SH_FRAC;
                SH_FRAC:
                    if (dig) return SH_FRAC;
                    else if (ex) return SH_EXP;
                SH_EXP:
                    if (sgn) return SH_EXPSIGN;
                    else if (dig) return SH_EXPDIG;
                SH_EXPSIGN, SH_EXPDIG:
                    if (dig) return SH_EXPDIG;
                default: ;
            endcase
            return SH_BAD;
        endfunction

        function kind_t word_class(shape_t s);
            if (s == SH_INT || s == SH_FRAC || s == SH_EXPDIG)
                return KIND_NUMBER;
            return KIND_SYMBOL;
        endfunction

        function void string_byte(logic [7:0] c);
            mode    = MODE_STR;
            esc_cnt = 2'd0;
            esc_val = 9'd0;
            if (c == CH_QUOTE) begin
                push(CH_NUL, 1'b0, 1'b1, KIND_STRING);
                mode = MODE_BETWEEN;
            end else if (c == CH_BSLASH) begin
                mode = MODE_ESC;
            end else if (c == CH_LF) begin
                push(CH_NUL, 1'b0, 1'b1, KIND_ERROR);
                restart_line();
            end else begin
                push(c, 1'b1, 1'b0, KIND_STRING);
            end
        endfunction

        function void between_byte(logic [7:0] c);
            if (in_comment) begin
                if (c == CH_LF) begin
                    in_comment = 1'b0;
                    line_start = 1'b1;
                end
                return;
            end
            if (is_blank(c)) begin
                if (c == CH_LF)
                    line_start = 1'b1;
                return;
            end
            if (line_start && c == CH_HASH) begin
                in_comment = 1'b1;
                return;
            end
            line_start = 1'b0;
            if (c == CH_LPAREN)
                push(c, 1'b1, 1'b1, KIND_LEFT);
            else if (c == CH_RPAREN)
                push(c, 1'b1, 1'b1, KIND_RIGHT);
            else if (bar_tok && c == CH_BAR)
                push(c, 1'b1, 1'b1, KIND_BAR);
            else if (c == CH_QUOTE) begin
                mode    = MODE_STR;
                esc_cnt = 2'd0;
                esc_val = 9'd0;
            end else begin
                mode  = MODE_WORD;
                shape = next_shape(SH_START, c);
                push(c, 1'b1, 1'b0, KIND_SYMBOL);
            end
        endfunction

        function void escape_byte(logic [7:0] c);
            logic [7:0] v;
            logic       letter;
            letter = 1'b1;
            v      = c;
            case (c)
                CH_QUOTE:  v = CH_QUOTE;
                CH_BSLASH: v = CH_BSLASH;
                "a":       v = CH_BEL;
                "b":       v = CH_BS;
                "f":       v = CH_FF;
                "n":       v = CH_LF;
                "r":       v = CH_CR;
                "t":       v = CH_TAB;
                "v":       v = CH_VT;
                default:   letter = 1'b0;
            endcase
            if (letter) begin
                push(v, 1'b1, 1'b0, KIND_STRING);
                mode = MODE_STR;
            end else if (c == CH_LOW_X) begin
                mode    = MODE_HEX;
                esc_cnt = 2'd0;
                esc_val = 9'd0;
            end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                mode    = MODE_OCT;
                esc_cnt = 2'd1;
                esc_val = {6'd0, c[2:0]};
            end else begin
                // unknown escape: keep the backslash, then treat the byte as plain text
                push(CH_BSLASH, 1'b1, 1'b0, KIND_STRING);
                string_byte(c);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic eos);
            logic [4:0] h;
            step_out.delete();
            if (eos) begin
                if (mode == MODE_WORD)
                    push(CH_NUL, 1'b0, 1'b1, word_class(shape));
                else if (mode != MODE_BETWEEN)
                    push(CH_NUL, 1'b0, 1'b1, KIND_ERROR);
                push(CH_NUL, 1'b0, 1'b1, KIND_EOI);
                restart_line();
            end else begin
                case (mode)
                    MODE_WORD:
                        if (is_delim(b)) begin
                            push(CH_NUL, 1'b0, 1'b1, word_class(shape));
                            mode  = MODE_BETWEEN;
                            shape = SH_START;
                            between_byte(b);
                        end else begin
                            shape = next_shape(shape, b);
                            push(b, 1'b1, 1'b0, KIND_SYMBOL);
                        end
                    MODE_STR:
                        string_byte(b);
                    MODE_ESC:
                        escape_byte(b);
                    MODE_HEX: begin
                        h = hex_of(b);
                        if (h[4]) begin
                            esc_val = {esc_val[4:0], h[3:0]};
                            esc_cnt = esc_cnt + 2'd1;
                            if (esc_cnt >= 2'd2) begin
                                push(esc_val[7:0], 1'b1, 1'b0, KIND_STRING);
                                mode    = MODE_STR;
                                esc_cnt = 2'd0;
                                esc_val = 9'd0;
                            end
                        end else begin
                            push((esc_cnt != 2'd0) ? esc_val[7:0] : CH_LOW_X,
                                 1'b1, 1'b0, KIND_STRING);
                            string_byte(b);
                        end
                    end
                    MODE_OCT:
                        if (b >= CH_ZERO && b <= CH_SEVEN) begin
                            esc_val = {esc_val[5:0], b[2:0]};
                            esc_cnt = esc_cnt + 2'd1;
                            if (esc_cnt >= 2'd3) begin
                                push(esc_val[7:0], 1'b1, 1'b0, KIND_STRING);
                                mode    = MODE_STR;
                                esc_cnt = 2'd0;
                                esc_val = 9'd0;
                            end
                        end else begin
                            push(esc_val[7:0], 1'b1, 1'b0, KIND_STRING);
                            string_byte(b);
                        end
                    MODE_BETWEEN:
                        between_byte(b);
                    default:
                        restart_line();
                endcase
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                pending_tokens.insert(pending_tokens.size(), step_out[i]);
        endfunction

        function void check_token(logic [7:0] text, logic fin, logic [4:0] user);
            result_t want;
            if (pending_tokens.size() == 0) begin
                note_failure($sformatf("unexpected token item text=%h end=%b user=%b",
                                       text, fin, user));
                return;
            end
            want = pending_tokens.pop_front();
            if (text !== want.text || fin !== want.token_end || user[0] !== want.has_text
                    || user[3:1] !== want.kind || user[4] !== want.last)
                note_failure({
                    $sformatf("token mismatch: exp text=%h has=%b end=%b kind=%0d last=%b",
                              want.text, want.has_text, want.token_end, want.kind,
                              want.last),
                    $sformatf(", got text=%h has=%b end=%b kind=%0d last=%b",
                              text, user[0], fin, user[3:1], user[4])});
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // data_byte
    logic        s_tlast  = 1'b0;   // end_of_stream
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // text_byte
    logic        m_tlast;           // token_end
    logic [4:0]  m_tuser;           // has_text [0], token_kind [3:1], last_of_item [4]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    token_scoreboard sb = new();
    int   sent_items   = 0;
    int   quiet_cycles = 0;
    logic src_idle     = 1'b1;
    logic snk_stall    = 1'b1;

    sexpr_token_lexer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= !(snk_stall && $urandom_range(99) < 29);
    end

    // Values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_token(m_tdata, m_tlast, m_tuser);
        end
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic eos);
        while (src_idle && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Hold the input until every predicted item has come out.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic wait_drained();
        hold_until_drained();
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BAR_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_bar(input logic v);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, {31'd0, v}, rd);
        sb.bar_tok = v;
        @(posedge clk);
        apb_access(1'b0, 32'd0, rd);
        if (rd[0] !== v)
            sb.note_failure($sformatf("bar_is_token reads %b after writing %b", rd[0], v));
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_LF;
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(9))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_BAR;
            default: return pick_blank();
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_hex();
        case ($urandom_range(2))
            0:       return pick_digit();
            1:       return 8'("a" + $urandom_range(5));
            default: return 8'("A" + $urandom_range(5));
        endcase
    endfunction

    function automatic logic [7:0] pick_sign();
        return $urandom_range(1) ? CH_PLUS : CH_MINUS;
    endfunction

    function automatic logic [7:0] pick_word_byte();
        case ($urandom_range(11))
            0:       return CH_QUOTE;
            1:       return CH_HASH;
            2:       return CH_BSLASH;
            3:       return CH_BAR;
            4:       return CH_DOT;
            5:       return pick_sign();
            6:       return 8'($urandom_range(128, 255));
            7:       return pick_digit();
            8:       return "e";
            default: return 8'("a" + $urandom_range(25));
        endcase
    endfunction

    function automatic logic [7:0] pick_escape_letter();
        case ($urandom_range(8))
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return "a";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            7:       return "t";
            default: return "v";
        endcase
    endfunction

    task automatic send_number();
        if ($urandom_range(2) == 0)
            send_byte(pick_sign());
        repeat ($urandom_range(3)) send_byte(pick_digit());
        if ($urandom_range(1))
        begin
            send_byte(CH_DOT);
            repeat ($urandom_range(3)) send_byte(pick_digit());
        end
        if ($urandom_range(2) == 0)
        begin
            send_byte($urandom_range(1) ? "e" : "E");
            if ($urandom_range(1))
                send_byte(pick_sign());
            repeat ($urandom_range(2)) send_byte(pick_digit());
        end
        if ($urandom_range(9) == 0)
            send_byte(pick_word_byte());
        send_byte(pick_sep());
    endtask

    task automatic send_symbol();
        send_byte(8'("A" + $urandom_range(25)));
        repeat ($urandom_range(4)) send_byte(pick_word_byte());
        send_byte(pick_sep());
    endtask

    task automatic send_string();
        logic [7:0] c;
        send_byte(CH_QUOTE);
        repeat ($urandom_range(6))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    c = 8'($urandom_range(32, 126));
                    send_byte((c == CH_QUOTE || c == CH_BSLASH) ? "k" : c);
                end
                4:
                    send_byte(8'($urandom_range(128, 255)));
                5:
                begin
                    send_byte(CH_BSLASH);
                    send_byte(pick_escape_letter());
                end
                6:
                begin
                    send_byte(CH_BSLASH);
                    send_byte(CH_LOW_X);
                    repeat ($urandom_range(3)) send_byte(pick_hex());
                end
                7:
                begin
                    send_byte(CH_BSLASH);
                    repeat ($urandom_range(1, 4)) send_byte(8'(CH_ZERO + $urandom_range(7)));
                end
                8:
                begin
                    send_byte(CH_BSLASH);
                    send_byte(8'($urandom));
                end
                default:
                    send_byte(8'($urandom));
            endcase
        end
        // close most strings; break some with a newline or the end of input
        case ($urandom_range(19))
            16, 17:  send_byte(CH_LF);
            18, 19:  send_end();
            default: send_byte(CH_QUOTE);
        endcase
    endtask

    task automatic send_comment();
        logic [7:0] c;
        send_byte(CH_LF);
        repeat ($urandom_range(2)) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        send_byte(CH_HASH);
        repeat ($urandom_range(6))
        begin
            c = 8'($urandom);
            send_byte((c == CH_LF) ? "z" : c);
        end
        send_byte(CH_LF);
    endtask

    task automatic run_random(input int count);
        int   stop_at;
        logic paused;
        stop_at = sent_items + count;
        paused  = 1'b0;
        while (sent_items < stop_at)
        begin
            if (!paused && sent_items >= stop_at - count / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            case ($urandom_range(99)) inside
                [0:19]:  send_number();
                [20:39]: send_symbol();
                [40:64]: send_string();
                [65:79]: send_byte(pick_sep());
                [80:87]: send_comment();
                [88:92]: send_byte(pick_blank());
                [93:97]: send_byte(8'($urandom));
                default: send_end();
            endcase
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // comment line, parens, bar, odd bytes in a symbol, a number, string escapes
        send_text("#\n(|");
        send_byte(8'hFF);
        send_byte(CH_QUOTE);
        send_byte(CH_RPAREN);
        send_text("-.5E9");
        send_byte(CH_NUL);
        send_text("\"\\q\\x\\777\\1\n\"\\");
        send_end();

        set_bar(1'b0);
        run_random(380);

        set_bar(1'b1);
        src_idle  = 1'b0;
        snk_stall = 1'b0;
        run_random(380);

        set_bar(1'b0);
        src_idle  = 1'b1;
        snk_stall = 1'b1;
        run_random(380);

        set_bar(1'b1);
        run_random(380);

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
            sb.note_failure($sformatf("%0d token items never came out", sb.pending()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
sv/sxl_pkg.sv
sv/sexpr_token_lexer.sv
sv/sxl_check.sv
tb/sv/sexpr_token_lexer_test.sv
